/* rtl/core/b64d_pkg.sv */
// Package for the Base64 stream decoder: widths, character codes, the
// symbol map, the front state enum and the job record passed to the back end.
// No dependencies.
package b64d_pkg;

  localparam int CountW  = 16;
  localparam int LimitW  = 16;
  localparam int BcountW = 16;
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);

  localparam logic [LimitW-1:0] LimitReset = {LimitW{1'b1}};

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPad   = 8'h3d;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharSlash = 8'h2f;
  localparam logic [5:0] ValLower  = 6'd26;
  localparam logic [5:0] ValDigit  = 6'd52;
  localparam logic [5:0] ValPlus   = 6'd62;
  localparam logic [5:0] ValSlash  = 6'd63;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [1:0] {
    PhDecode = 2'd0,
    PhDone   = 2'd1,
    PhError  = 2'd2
  } phase_e;

  typedef struct packed {
    logic       bad;
    logic       pad;
    logic [5:0] val;
  } sym_t;

  typedef struct packed {
    logic [23:0]        bits;
    logic [1:0]         n_data;
    logic               has_status;
    logic               status;
    logic [BcountW-1:0] count;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic sym_t map_symbol(input logic [7:0] c);
    sym_t s;
    s = '{bad: 1'b0, pad: 1'b0, val: 6'd0};
    if (c >= 8'h41 && c <= 8'h5a) begin
      s.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      s.val = 6'(c - 8'h61) + ValLower;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.val = 6'(c - 8'h30) + ValDigit;
    end else if (c == CharPlus) begin
      s.val = ValPlus;
    end else if (c == CharSlash) begin
      s.val = ValSlash;
    end else if (c == CharPad) begin
      s.pad = 1'b1;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

endpackage

/* rtl/core/b64d_if.sv */
// Valid/ready channel interfaces for the Base64 stream decoder: input
// characters, result items and the limit register write channel.
// No dependencies.
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;
  modport source (output valid, char_code, end_of_input, input ready);
  modport sink (input valid, char_code, end_of_input, output ready);
endinterface

interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic        status;
  logic [15:0] byte_count;
  logic        run_end;
  modport source (output valid, kind, data_byte, status, byte_count, run_end, input ready);
  modport sink (input valid, kind, data_byte, status, byte_count, run_end, output ready);
endinterface

interface b64d_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/core/base64_stream_decoder.sv */
// Base64 stream decoder top level: front end, job queue and back end.
// Jobs are held in a registered queue between the front and back ends.
// Throughput: one character per cycle while the queue is not full; the
// back end sends one result per cycle while the output is ready.
// Reset: asynchronous, active low; clears the message state and the queue
// and sets the output limit to 65535. Uses b64d_pkg and b64d_if.
module base64_stream_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  b64d_in_if.sink    in_i,
  b64d_cfg_if.sink   cfg_i,
  b64d_out_if.source out_o
);
  import b64d_pkg::*;

  logic    push;
  logic    pop;
  job_t    job;
  job_t    head;
  q_stat_t q_stat;

  b64d_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .job_o    (job)
  );

  b64d_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  b64d_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

/* rtl/core/b64d_front.sv */
// Front end of the Base64 stream decoder: accepts characters, decodes
// groups, applies the output limit and pushes jobs. Uses b64d_pkg and b64d_if.
module b64d_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  b64d_in_if.sink              in_i,
  b64d_cfg_if.sink             cfg_i,
  input  b64d_pkg::q_stat_t    q_stat_i,
  output logic                 push_o,
  output b64d_pkg::job_t       job_o
);
  import b64d_pkg::*;

  localparam logic [31:0] CapW = 32'((64'(1) << CountW) - 64'(1));

  logic [LimitW-1:0] limit_q;
  logic [1:0]        fill_q, fill_d;
  logic [23:0]       bits_q, bits_d;
  logic [2:0]        pads_q, pads_d;
  logic [CountW-1:0] bytes_q, bytes_d;
  phase_e            phase_q, phase_d;

  logic        fire;
  logic        last;
  sym_t        sym;
  logic [23:0] bits_new;
  logic [2:0]  pads_new;
  logic [1:0]  nb;
  logic [1:0]  n_emit;
  logic [31:0] lim;
  logic [31:0] room;
  logic        bad_end;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !q_stat_i.full;
  assign fire        = in_i.valid && in_i.ready;
  assign last        = in_i.end_of_input;
  assign sym         = map_symbol(in_i.char_code);
  assign lim         = (32'(limit_q) < CapW) ? 32'(limit_q) : CapW;
  assign room        = (32'(bytes_q) < lim) ? (lim - 32'(bytes_q)) : 32'd0;

  always_comb begin
    pads_new = sym.pad ? pads_q + 3'd1 : pads_q;
    bits_new = {bits_q[17:0], (sym.pad ? 6'd0 : sym.val)};
    unique case (pads_new)
      3'd0:    nb = 2'd3;
      3'd1:    nb = 2'd2;
      3'd2:    nb = 2'd1;
      default: nb = 2'd0;
    endcase
  end

  always_comb begin
    fill_d  = fill_q;
    bits_d  = bits_q;
    pads_d  = pads_q;
    bytes_d = bytes_q;
    phase_d = phase_q;
    n_emit  = 2'd0;
    if (phase_q == PhDecode && in_i.char_code > CharSpace) begin
      if (sym.bad) begin
        phase_d = PhError;
      end else if (fill_q == 2'd3) begin
        n_emit  = (room < 32'(nb)) ? room[1:0] : nb;
        bytes_d = bytes_q + CountW'(n_emit);
        if (pads_new != 3'd0) begin
          phase_d = PhDone;
        end
        fill_d = 2'd0;
        bits_d = 24'd0;
        pads_d = 3'd0;
      end else begin
        fill_d = fill_q + 2'd1;
        bits_d = bits_new;
        pads_d = pads_new;
      end
    end
  end

  assign bad_end = (phase_d != PhDecode && phase_d != PhDone) || fill_d != 2'd0
                   || limit_q == '0;

  always_comb begin
    job_o.bits       = bits_new;
    job_o.n_data     = n_emit;
    job_o.has_status = last;
    job_o.status     = bad_end;
    job_o.count      = BcountW'(bytes_d);
    push_o           = fire && (n_emit != 2'd0 || last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= 2'd0;
      bits_q  <= 24'd0;
      pads_q  <= 3'd0;
      bytes_q <= '0;
      phase_q <= PhDecode;
    end else if (fire) begin
      if (last) begin
        fill_q  <= 2'd0;
        bits_q  <= 24'd0;
        pads_q  <= 3'd0;
        bytes_q <= '0;
        phase_q <= PhDecode;
      end else begin
        fill_q  <= fill_d;
        bits_q  <= bits_d;
        pads_q  <= pads_d;
        bytes_q <= bytes_d;
        phase_q <= phase_d;
      end
    end
  end

endmodule

/* rtl/core/b64d_queue.sv */
// Job queue between the front and back ends of the Base64 stream decoder.
// Register array with read and write pointers; uses b64d_pkg.
module b64d_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64d_pkg::job_t    job_i,
  input  logic              pop_i,
  output b64d_pkg::job_t    head_o,
  output b64d_pkg::q_stat_t stat_o
);
  import b64d_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             do_push;
  logic             do_pop;

  assign stat_o.full  = cnt_q == (QPtrW+1)'(QDepth);
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (QPtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (QPtrW+1)'(1);
      end
    end
  end

endmodule

/* rtl/core/b64d_back.sv */
// Back end of the Base64 stream decoder: turns the job at the queue head
// into data and status results. Uses b64d_pkg and b64d_if.
module b64d_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b64d_pkg::job_t    head_i,
  input  b64d_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  b64d_out_if.source        out_o
);
  import b64d_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic [2:0] total;
  logic       is_status;
  logic       is_last;
  logic       fire;

  assign total     = 3'(head_i.n_data) + 3'(head_i.has_status);
  assign is_status = idx_q == head_i.n_data;
  assign is_last   = 3'(idx_q) == total - 3'd1;
  assign fire      = out_o.valid && out_o.ready;
  assign pop_o     = fire && is_last;

  always_comb begin
    out_o.valid      = !q_stat_i.empty;
    out_o.kind       = is_status ? KindStatus : KindData;
    out_o.status     = is_status ? head_i.status : 1'b0;
    out_o.byte_count = is_status ? head_i.count : '0;
    out_o.run_end    = is_last;
    unique case (idx_q)
      2'd0:    out_o.data_byte = head_i.bits[23:16];
      2'd1:    out_o.data_byte = head_i.bits[15:8];
      2'd2:    out_o.data_byte = head_i.bits[7:0];
      default: out_o.data_byte = 8'd0;
    endcase
    if (is_status) begin
      out_o.data_byte = 8'd0;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

/* sim/tb_base64_stream_decoder.sv */
// Self-checking testbench for the Base64 stream decoder: a directed table and
// random messages under several output limits and idle patterns, each result
// compared against an in-bench decoder. Uses b64d_pkg, b64d_if and the RTL top.
module tb_base64_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;

  localparam int CycleLimit    = 200000;
  localparam int DirRowCount   = 28;
  localparam int PhaseCount    = 8;
  localparam int ItemsPerPhase = 24;
  localparam int HoldCycles    = 150;
  localparam int LongGroups    = 12;
  localparam int SettleCycles  = 8;
  localparam int ShowLimit     = 10;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        status;
    logic [15:0] byte_count;
    logic        run_end;
  } dec_result_t;

  typedef enum logic {
    RowChar,
    RowLimit
  } row_op_e;

  typedef struct packed {
    row_op_e     op;
    logic [15:0] value;
    logic        eoi;
    logic        pinned;
    logic        pin_status;
    logic [15:0] pin_count;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  b64d_in_if  in_if ();
  b64d_cfg_if cfg_if ();
  b64d_out_if out_if ();

  base64_stream_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [15:0] limit_q = LimitReset;
  logic [1:0]  fill_q  = 2'd0;
  logic [23:0] bits_q  = 24'd0;
  logic [2:0]  pads_q  = 3'd0;
  logic [15:0] bytes_q = 16'd0;
  phase_e      phase_q = PhDecode;

  dec_result_t pending_results[$];
  dec_result_t want_r;
  dir_row_t    dir_tbl [DirRowCount];

  int fail_cnt;
  int chars_sent;
  int msgs_sent;
  int results_seen;
  int in_idle_pct;
  int out_stall_pct;
  int hold_req;
  int hold_done;
  int cycle_cnt;

  task automatic decode_char(input logic [7:0] c, input logic eoi, input logic pinned,
                             input logic pin_status, input logic [15:0] pin_count);
    dec_result_t res [4];
    dec_result_t r;
    logic [5:0]  v;
    logic        is_pad;
    logic        is_bad;
    logic        bad;
    int          nb;
    int          n;
    n = 0;
    v = 6'd0;
    is_pad = 1'b0;
    is_bad = 1'b0;
    if (phase_q == PhDecode && c > CharSpace) begin
      if (c >= "A" && c <= "Z") begin
        v = 6'(c - "A");
      end else if (c >= "a" && c <= "z") begin
        v = 6'(c - "a") + ValLower;
      end else if (c >= "0" && c <= "9") begin
        v = 6'(c - "0") + ValDigit;
      end else if (c == CharPlus) begin
        v = ValPlus;
      end else if (c == CharSlash) begin
        v = ValSlash;
      end else if (c == CharPad) begin
        is_pad = 1'b1;
      end else begin
        is_bad = 1'b1;
      end
      if (is_bad) begin
        phase_q = PhError;
      end else begin
        if (is_pad) begin
          pads_q = pads_q + 3'd1;
        end
        bits_q = {bits_q[17:0], v};
        if (fill_q == 2'd3) begin
          nb = (pads_q == 3'd0) ? 3 : (pads_q == 3'd1) ? 2 : (pads_q == 3'd2) ? 1 : 0;
          for (int i = 0; i < nb; i++) begin
            if (bytes_q < limit_q) begin
              res[n] = {KindData, bits_q[23-8*i -: 8], 1'b0, 16'd0, 1'b0};
              n++;
              bytes_q = bytes_q + 16'd1;
            end
          end
          if (pads_q != 3'd0) begin
            phase_q = PhDone;
          end
          fill_q = 2'd0;
          bits_q = 24'd0;
          pads_q = 3'd0;
        end else begin
          fill_q = fill_q + 2'd1;
        end
      end
    end
    if (eoi) begin
      bad = (phase_q != PhDecode && phase_q != PhDone) || fill_q != 2'd0 || limit_q == 16'd0;
      res[n] = {KindStatus, 8'd0, pinned ? pin_status : bad, pinned ? pin_count : bytes_q, 1'b0};
      n++;
      fill_q  = 2'd0;
      bits_q  = 24'd0;
      pads_q  = 3'd0;
      bytes_q = 16'd0;
      phase_q = PhDecode;
    end
    for (int k = 0; k < n; k++) begin
      r = res[k];
      r.run_end = (k == n - 1);
      pending_results.push_back(r);
    end
  endtask

  task automatic push_char(input logic [7:0] c, input logic eoi, input logic pinned,
                           input logic pin_status, input logic [15:0] pin_count);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.char_code    <= c;
    in_if.end_of_input <= eoi;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    decode_char(c, eoi, pinned, pin_status, pin_count);
    chars_sent++;
    if (eoi) begin
      msgs_sent++;
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] value);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    limit_q = value;
  endtask

  task automatic send_message(input int long_groups);
    logic [7:0] msg[$];
    logic [7:0] c;
    int         sel;
    int         groups;
    int         pads;
    int         pos;
    int         v;
    bit         scatter;
    sel = (long_groups > 0) ? 0 : $urandom_range(99);
    if (sel < 90) begin
      if (long_groups > 0) begin
        groups = long_groups;
        pads   = 0;
      end else begin
        groups = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
        pads   = ($urandom_range(19) < 17) ? $urandom_range(0, 2) : $urandom_range(3, 4);
      end
      scatter = ($urandom_range(3) == 0);
      for (int g = 0; g < groups; g++) begin
        for (int k = 0; k < 4; k++) begin
          if (long_groups == 0 && $urandom_range(11) == 0) begin
            msg.push_back(8'($urandom_range(0, 32)));
          end
          if (g == groups - 1 && (scatter ? ($urandom_range(3) < pads) : (k >= 4 - pads))) begin
            c = CharPad;
          end else begin
            v = $urandom_range(63);
            c = (v < 26) ? 8'("A" + v) : (v < 52) ? 8'("a" + v - 26) :
                (v < 62) ? 8'("0" + v - 52) : (v == 62) ? CharPlus : CharSlash;
          end
          msg.push_back(c);
        end
      end
      if (long_groups == 0 && $urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(0, 255)));
      end
      if (sel >= 75 && msg.size() > 0) begin
        if ($urandom_range(1) == 1) begin
          repeat ($urandom_range(1, 3)) begin
            if (msg.size() > 1) begin
              c = msg.pop_back();
            end
          end
        end else begin
          pos = $urandom_range(0, msg.size() - 1);
          do begin
            c = 8'($urandom_range(33, 255));
          end while ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                     (c >= "0" && c <= "9") || c == CharPlus || c == CharSlash ||
                     c == CharPad);
          msg[pos] = c;
        end
      end
    end else begin
      repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom_range(0, 255)));
    end
    if (msg.size() == 0) begin
      msg.push_back(8'($urandom_range(0, 32)));
    end
    foreach (msg[i]) begin
      push_char(msg[i], i == msg.size() - 1, 1'b0, 1'b0, 16'd0);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= ShowLimit) begin
          $display("Unexpected result: kind %0b byte %02h status %0b count %0d last %0b",
                   out_if.kind, out_if.data_byte, out_if.status, out_if.byte_count,
                   out_if.run_end);
        end
      end else begin
        want_r = pending_results.pop_front();
        if (out_if.kind !== want_r.kind || out_if.data_byte !== want_r.data_byte ||
            out_if.status !== want_r.status || out_if.byte_count !== want_r.byte_count ||
            out_if.run_end !== want_r.run_end) begin
          fail_cnt++;
          if (fail_cnt <= ShowLimit) begin
            $display("Mismatch on result %0d: expected kind %0b byte %02h status %0b count %0d last %0b",
                     results_seen, want_r.kind, want_r.data_byte, want_r.status,
                     want_r.byte_count, want_r.run_end);
            $display("  got kind %0b byte %02h status %0b count %0d last %0b",
                     out_if.kind, out_if.data_byte, out_if.status, out_if.byte_count,
                     out_if.run_end);
          end
        end
      end
    end
    if (hold_done < hold_req) begin
      out_if.ready <= 1'b0;
      hold_done <= hold_done + 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.", cycle_cnt,
             pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    dir_row_t    row;
    logic [15:0] lim_set [PhaseCount];
    int          start;
    in_if.valid        = 1'b0;
    in_if.char_code    = 8'd0;
    in_if.end_of_input = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.data        = 16'd0;
    out_if.ready       = 1'b0;
    dir_tbl = '{
      '{RowChar,  16'h0000, 1'b1, 1'b1, 1'b0, 16'd0},
      '{RowChar,  "A",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "Z",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "a",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "z",      1'b1, 1'b1, 1'b0, 16'd3},
      '{RowChar,  "0",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "9",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "+",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "/",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "=",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "Q",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "=",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "=",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  16'h00ff, 1'b1, 1'b1, 1'b0, 16'd3},
      '{RowChar,  "Q",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "U",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "J",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "D",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "!",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  16'h0020, 1'b1, 1'b1, 1'b1, 16'd3},
      '{RowChar,  "Q",      1'b1, 1'b1, 1'b1, 16'd0},
      '{RowLimit, 16'd2,    1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "Q",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "U",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "J",      1'b0, 1'b0, 1'b0, 16'd0},
      '{RowLimit, 16'd0,    1'b0, 1'b0, 1'b0, 16'd0},
      '{RowChar,  "D",      1'b1, 1'b1, 1'b1, 16'd0},
      '{RowLimit, 16'hffff, 1'b0, 1'b0, 1'b0, 16'd0}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRowCount; i++) begin
      row = dir_tbl[i];
      if (row.op == RowLimit) begin
        write_limit(row.value);
      end else begin
        push_char(row.value[7:0], row.eoi, row.pinned, row.pin_status, row.pin_count);
      end
    end

    lim_set = '{16'hffff, 16'd0, 16'd1, 16'd2, 16'd7, 16'($urandom_range(4, 30)), 16'd3,
                16'hffff};
    for (int p = 0; p < PhaseCount; p++) begin
      write_limit(lim_set[p]);
      case (p % 4)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct   = 66;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 66;
        end
        default: begin
          in_idle_pct   = 23;
          out_stall_pct = 23;
        end
      endcase
      // The output is held off while a long message streams in, so the
      // decoder fills up and has to stall its input.
      if (p == 0) begin
        hold_req = hold_req + HoldCycles;
        send_message(LongGroups);
      end
      start = chars_sent;
      while (chars_sent - start < ItemsPerPhase) send_message(0);
    end

    wait_idle();
    fail_cnt += pending_results.size();
    $display("Sent %0d characters in %0d messages and checked %0d results.", chars_sent,
             msgs_sent, results_seen);
    $display("Limits 65535, 0, 1, 2, 3, 7 and one random, under four idle patterns.");
    if (fail_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* base64_stream_decoder.f */
rtl/core/b64d_pkg.sv
rtl/core/b64d_if.sv
rtl/core/b64d_front.sv
rtl/core/b64d_queue.sv
rtl/core/b64d_back.sv
rtl/core/base64_stream_decoder.sv
sim/tb_base64_stream_decoder.sv
